[design/heading_hold_correction_top_defines.svh]
// Assertion macros shared by the heading hold correction RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef HEADING_HOLD_CORRECTION_TOP_DEFINES_SVH
`define HEADING_HOLD_CORRECTION_TOP_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define HHC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked only out of reset.
`define HHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/hhc_pkg.sv]
// Package for the heading hold correction block: constants, register map,
// sequencer state encoding and divider sizing. No dependencies.
`default_nettype none

package hhc_pkg;

  // Angles are Q.12 radians.
  localparam int TWO_PI_Q  = 25736;
  localparam int PI_Q      = 12868;
  localparam int HALF_Q24  = 8388608;
  localparam int RATE_DIV  = 50;
  localparam int OVS_DIV   = 5;
  localparam logic [2:0] LOCKOUT_TICKS = 3'd5;

  // Reciprocals for the constant divisions. x*RATE_RECIP >> RATE_SHIFT equals x/50 for
  // x below 199728, and x*OVS_RECIP >> OVS_SHIFT equals x/5 for any 18-bit x.
  localparam int RATE_RECIP = 167773;
  localparam int RATE_SHIFT = 23;
  localparam int OVS_RECIP  = 209716;
  localparam int OVS_SHIFT  = 20;

  // Register reset values.
  localparam logic [15:0] DRIFT_GAIN_RST     = 16'd4096;
  localparam logic [12:0] MIN_POWER_RST      = 13'd1229;
  localparam logic [12:0] TURN_DEADBAND_RST  = 13'd328;
  localparam logic [12:0] DRIFT_DEADBAND_RST = 13'd18;

  localparam int PADDR_W = 4;

  // Shared divider sizing: a 48-bit dividend covers the growth-term product,
  // and 28 bits covers 100 times the largest denominator.
  localparam int DIV_NUM_W = 48;
  localparam int DIV_DEN_W = 28;

  typedef enum logic [1:0] {
    REG_DRIFT_GAIN     = 2'd0,
    REG_MIN_POWER      = 2'd1,
    REG_TURN_DEADBAND  = 2'd2,
    REG_DRIFT_DEADBAND = 2'd3
  } reg_idx_t;

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_RDIV   = 16'h0002,
    S_DRIFT  = 16'h0004,
    S_GMUL   = 16'h0008,
    S_GCLAMP = 16'h0010,
    S_MMUL   = 16'h0020,
    S_MAG    = 16'h0040,
    S_SEL    = 16'h0080,
    S_ODIV   = 16'h0100,
    S_DEN    = 16'h0200,
    S_NUM    = 16'h0400,
    S_PMUL   = 16'h0800,
    S_PSTART = 16'h1000,
    S_PDIV   = 16'h2000,
    S_DONE   = 16'h4000,
    S_SPARE  = 16'h8000
  } state_t;

endpackage

`default_nettype wire

[design/hhc_div.sv]
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on hhc_pkg for its default operand widths.
`default_nettype none

module hhc_div
  import hhc_pkg::*;
#(
  parameter int NUM_W = DIV_NUM_W,
  parameter int DEN_W = DIV_DEN_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output logic                  done,
  output logic      [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] dq_r, dq_nxt;
  logic [DEN_W-1:0] dvs_r, dvs_nxt;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // The dividend shifts out at the top while quotient bits shift in below.
  assign trial = {rem_r, dq_r[NUM_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      rem_nxt  = '0;
      dq_nxt   = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      dq_nxt  = {dq_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

`default_nettype wire

[design/heading_hold_correction_top.sv]
// Path: a beat accepted with hold off goes to S_DONE, a turn passes through S_RDIV, the drift
// path runs S_DRIFT to S_SEL, an overshoot adds S_ODIV, and a growing drift adds S_DEN to S_PDIV.
// Throughput: one beat at a time; the next beat is taken once the sequencer is back in S_IDLE,
// after the result enters the output register, and S_DONE holds while a valid result stalls.
// Reset (synchronous, rst_n low) clears hold, lockout, target and history state and loads
// the register defaults.
`default_nettype none

module heading_hold_correction_top
  import hhc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Input channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_hold_button,
  input  wire logic signed [13:0]  in_turn_demand,
  input  wire logic        [14:0]  in_heading_now,
  input  wire logic signed [17:0]  in_spin_rate,
  // Result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed      [15:0]  out_correction,
  output logic                     out_hold_on,
  output logic signed      [14:0]  out_drift_out,
  output logic             [14:0]  out_target_out,
  // Configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic       [31:0]   pwdata,
  output logic            [31:0]   prdata,
  output logic                     pready
);

`include "heading_hold_correction_top_defines.svh"

  // Configuration registers
  logic signed [15:0] gain_r, gain_nxt;
  logic        [12:0] mp_r, mp_nxt;
  logic        [12:0] tdb_r, tdb_nxt;
  logic        [12:0] ddb_r, ddb_nxt;

  // Control and history state
  state_t             state_r, state_nxt;
  logic        [2:0]  lockout_r, lockout_nxt;
  logic               last_button_r, last_button_nxt;
  logic               hold_r, hold_nxt;
  logic        [14:0] target_r, target_nxt;
  logic signed [14:0] last_drift_r, last_drift_nxt;
  logic signed [15:0] last_corr_r, last_corr_nxt;
  logic               div_start_r, div_start_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Datapath registers
  logic        [14:0] heading_r, heading_nxt;
  logic               rate_neg_r, rate_neg_nxt;
  logic        [35:0] rprod_r, rprod_nxt;
  logic signed [14:0] d_r, d_nxt;
  logic        [14:0] ad_r, ad_nxt;
  logic signed [30:0] gprod_r, gprod_nxt;
  logic        [23:0] g_r, g_nxt;
  logic signed [38:0] mprod_r, mprod_nxt;
  logic signed [15:0] c_r, c_nxt;
  logic        [35:0] oprod_r, oprod_nxt;
  logic        [16:0] m_r, m_nxt;
  logic        [20:0] den_r, den_nxt;
  logic signed [31:0] num_r, num_nxt;
  logic signed [49:0] pm_r, pm_nxt;
  logic [DIV_NUM_W-1:0] div_a_r, div_a_nxt;
  logic [DIV_DEN_W-1:0] div_b_r, div_b_nxt;
  logic               res_neg_r, res_neg_nxt;
  logic signed [15:0] res_corr_r, res_corr_nxt;
  logic signed [14:0] res_drift_r, res_drift_nxt;
  logic signed [15:0] out_corr_r, out_corr_nxt;
  logic signed [14:0] out_drift_r, out_drift_nxt;
  logic               out_hold_r, out_hold_nxt;
  logic        [14:0] out_target_r, out_target_nxt;

  // Divider
  logic               div_done;
  logic [DIV_NUM_W-1:0] div_q;

  // Combinational helpers
  logic               cfg_wr;
  reg_idx_t           reg_idx;
  logic        [14:0] turn_ext, turn_abs;
  logic        [18:0] rate_ext, rate_abs;
  logic signed [16:0] rq_s, t_raw, t_wrap;
  logic signed [16:0] dr, dw;
  logic        [14:0] d_abs;
  logic        [30:0] gabs;
  logic signed [13:0] pw;
  logic        [38:0] mabs;
  logic        [15:0] sq, mag;
  logic               d_pos, d_neg, p_neg, ovs, grow;
  logic        [14:0] p_abs;
  logic        [16:0] c_ext, c_abs, lc_ext, lc_abs;
  logic        [17:0] c3;
  logic        [15:0] oq;
  logic signed [15:0] ovs_corr;
  logic signed [15:0] sd;
  logic        [16:0] sdx;
  logic        [49:0] pm_abs;
  logic signed [15:0] sat_corr;

  hhc_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_a_r),
    .divisor  (div_b_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign pready  = 1'b1;

  always_comb begin
    unique case (reg_idx)
      REG_DRIFT_GAIN:     prdata = {{16{gain_r[15]}}, gain_r};
      REG_MIN_POWER:      prdata = {19'd0, mp_r};
      REG_TURN_DEADBAND:  prdata = {19'd0, tdb_r};
      REG_DRIFT_DEADBAND: prdata = {19'd0, ddb_r};
      default:            prdata = '0;
    endcase
  end

  // Arithmetic helpers, each feeding one sequencer step.
  always_comb begin
    turn_ext = {in_turn_demand[13], in_turn_demand};
    turn_abs = turn_ext[14] ? (~turn_ext + 15'd1) : turn_ext;
    rate_ext = {in_spin_rate[17], in_spin_rate};
    rate_abs = rate_ext[18] ? (~rate_ext + 19'd1) : rate_ext;

    // Target follows heading plus the rate term, wrapped once.
    rq_s = $signed({5'd0, rprod_r[RATE_SHIFT +: 12]});
    if (rate_neg_r) begin
      rq_s = -rq_s;
    end
    t_raw  = $signed({2'b00, heading_r}) + rq_s;
    t_wrap = t_raw;
    if (t_raw < 0) begin
      t_wrap = 17'(t_raw + TWO_PI_Q);
    end else if (t_raw > TWO_PI_Q) begin
      t_wrap = 17'(t_raw - TWO_PI_Q);
    end

    dr = $signed({2'b00, target_r}) - $signed({2'b00, heading_r});
    dw = dr;
    if (dr > PI_Q) begin
      dw = 17'(dr - TWO_PI_Q);
    end else if (dr < -PI_Q) begin
      dw = 17'(dr + TWO_PI_Q);
    end

    d_abs = d_r[14] ? (~d_r + 15'd1) : d_r;
    gabs  = gprod_r[30] ? (~gprod_r + 31'd1) : gprod_r;
    pw    = $signed(14'd4096 - {1'b0, mp_r});

    // Q.24 to Q.12 truncates toward zero, so work on the magnitude.
    mabs = mprod_r[38] ? (~mprod_r + 39'd1) : mprod_r;
    sq   = {1'b0, mabs[38:24]};
    if (mprod_r[38]) begin
      sq = ~sq + 16'd1;
    end
    mag = {3'd0, mp_r} + sq;

    d_pos = !d_r[14] && (d_r != '0);
    d_neg = d_r[14];
    p_neg = last_drift_r[14];
    ovs   = (d_pos && p_neg) || (d_neg && !p_neg);
    p_abs = last_drift_r[14] ? (~last_drift_r + 15'd1) : last_drift_r;
    grow  = (19'(ad_r) * 19'd10) > (19'(p_abs) * 19'd9);

    c_ext  = {c_r[15], c_r};
    c_abs  = c_ext[16] ? (~c_ext + 17'd1) : c_ext;
    c3     = 18'(c_abs) * 18'd3;
    lc_ext = {last_corr_r[15], last_corr_r};
    lc_abs = lc_ext[16] ? (~lc_ext + 17'd1) : lc_ext;

    // Overshoot damping: the magnitude times 3/5 always fits in 16 bits.
    oq       = oprod_r[OVS_SHIFT +: 16];
    ovs_corr = res_neg_r ? $signed(16'd0 - oq) : $signed(oq);

    sd  = $signed({d_r[14], d_r}) - $signed({last_drift_r[14], last_drift_r});
    sdx = {sd[15], sd};
    if (d_r[14]) begin
      sdx = ~sdx + 17'd1;
    end

    pm_abs = pm_r[49] ? (~pm_r + 50'd1) : pm_r;

    if (res_neg_r) begin
      sat_corr = (div_q > DIV_NUM_W'(32768)) ? 16'sh8000 : $signed(16'd0 - div_q[15:0]);
    end else begin
      sat_corr = (div_q > DIV_NUM_W'(32767)) ? 16'sh7FFF : $signed(div_q[15:0]);
    end
  end

  // Sequencer
  always_comb begin
    gain_nxt        = gain_r;
    mp_nxt          = mp_r;
    tdb_nxt         = tdb_r;
    ddb_nxt         = ddb_r;
    state_nxt       = state_r;
    lockout_nxt     = lockout_r;
    last_button_nxt = last_button_r;
    hold_nxt        = hold_r;
    target_nxt      = target_r;
    last_drift_nxt  = last_drift_r;
    last_corr_nxt   = last_corr_r;
    div_start_nxt   = 1'b0;
    out_valid_nxt   = out_valid_r;
    heading_nxt     = heading_r;
    rate_neg_nxt    = rate_neg_r;
    rprod_nxt       = rprod_r;
    d_nxt           = d_r;
    ad_nxt          = ad_r;
    gprod_nxt       = gprod_r;
    g_nxt           = g_r;
    mprod_nxt       = mprod_r;
    c_nxt           = c_r;
    oprod_nxt       = oprod_r;
    m_nxt           = m_r;
    den_nxt         = den_r;
    num_nxt         = num_r;
    pm_nxt          = pm_r;
    div_a_nxt       = div_a_r;
    div_b_nxt       = div_b_r;
    res_neg_nxt     = res_neg_r;
    res_corr_nxt    = res_corr_r;
    res_drift_nxt   = res_drift_r;
    out_corr_nxt    = out_corr_r;
    out_drift_nxt   = out_drift_r;
    out_hold_nxt    = out_hold_r;
    out_target_nxt  = out_target_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_wr) begin
      unique case (reg_idx)
        REG_DRIFT_GAIN:     gain_nxt = $signed(pwdata[15:0]);
        REG_MIN_POWER:      mp_nxt   = pwdata[12:0];
        REG_TURN_DEADBAND:  tdb_nxt  = pwdata[12:0];
        REG_DRIFT_DEADBAND: ddb_nxt  = pwdata[12:0];
        default:            gain_nxt = gain_r;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          heading_nxt  = in_heading_now;
          rate_neg_nxt = in_spin_rate[17];
          if (lockout_r != 3'd0) begin
            lockout_nxt = lockout_r - 3'd1;
          end else begin
            if (in_hold_button && !last_button_r) begin
              hold_nxt = !hold_r;
            end
            // Outside the lockout, any button change latches the heading and starts the lockout.
            if (in_hold_button != last_button_r) begin
              lockout_nxt = LOCKOUT_TICKS;
              target_nxt  = in_heading_now;
            end
            last_button_nxt = in_hold_button;
          end
          if (!hold_nxt) begin
            res_corr_nxt  = '0;
            res_drift_nxt = '0;
            state_nxt     = S_DONE;
          end else if (turn_abs > {2'b00, tdb_r}) begin
            rprod_nxt = 36'(rate_abs) * 36'(RATE_RECIP);
            state_nxt = S_RDIV;
          end else begin
            state_nxt = S_DRIFT;
          end
        end
      end
      S_RDIV: begin
        target_nxt    = t_wrap[14:0];
        res_corr_nxt  = '0;
        res_drift_nxt = '0;
        state_nxt     = S_DONE;
      end
      S_DRIFT: begin
        d_nxt     = dw[14:0];
        state_nxt = S_GMUL;
      end
      S_GMUL: begin
        gprod_nxt = d_r * gain_r;
        ad_nxt    = d_abs;
        state_nxt = S_GCLAMP;
      end
      S_GCLAMP: begin
        g_nxt     = (gabs > 31'(HALF_Q24)) ? 24'(HALF_Q24) : gabs[23:0];
        state_nxt = S_MMUL;
      end
      S_MMUL: begin
        mprod_nxt = $signed({1'b0, g_r}) * pw;
        state_nxt = S_MAG;
      end
      S_MAG: begin
        if (ad_r >= {2'b00, ddb_r}) begin
          c_nxt = d_r[14] ? $signed(16'd0 - mag) : $signed(mag);
        end else begin
          c_nxt = '0;
        end
        state_nxt = S_SEL;
      end
      S_SEL: begin
        if (ovs) begin
          oprod_nxt   = 36'(c3) * 36'(OVS_RECIP);
          res_neg_nxt = c_r[15];
          state_nxt   = S_ODIV;
        end else if (grow) begin
          state_nxt = S_DEN;
        end else begin
          res_corr_nxt   = c_r;
          res_drift_nxt  = d_r;
          last_corr_nxt  = c_r;
          last_drift_nxt = d_r;
          state_nxt      = S_DONE;
        end
      end
      S_ODIV: begin
        res_corr_nxt   = ovs_corr;
        res_drift_nxt  = d_r;
        last_corr_nxt  = ovs_corr;
        last_drift_nxt = d_r;
        state_nxt      = S_DONE;
      end
      S_DEN: begin
        m_nxt       = (lc_abs > c_abs) ? lc_abs : c_abs;
        res_neg_nxt = c_r[15];
        den_nxt     = 21'd4096 + 21'(ad_r) * 21'd100;
        state_nxt   = S_NUM;
      end
      S_NUM: begin
        num_nxt   = $signed({11'd0, den_r}) * 32'sd101 + 32'($signed(sdx)) * 32'sd10000;
        state_nxt = S_PMUL;
      end
      S_PMUL: begin
        pm_nxt    = $signed({1'b0, m_r}) * num_r;
        state_nxt = S_PSTART;
      end
      S_PSTART: begin
        // M is held as a magnitude, so the quotient sign combines the sign of the
        // correction with the sign of the numerator.
        div_start_nxt = 1'b1;
        div_a_nxt     = pm_abs[DIV_NUM_W-1:0];
        div_b_nxt     = DIV_DEN_W'(28'(den_r) * 28'd100);
        res_neg_nxt   = res_neg_r ^ pm_r[49];
        state_nxt     = S_PDIV;
      end
      S_PDIV: begin
        if (div_done) begin
          res_corr_nxt   = sat_corr;
          res_drift_nxt  = d_r;
          last_corr_nxt  = sat_corr;
          last_drift_nxt = d_r;
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_corr_nxt   = res_corr_r;
          out_drift_nxt  = res_drift_r;
          out_hold_nxt   = hold_r;
          out_target_nxt = target_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r        <= DRIFT_GAIN_RST;
      mp_r          <= MIN_POWER_RST;
      tdb_r         <= TURN_DEADBAND_RST;
      ddb_r         <= DRIFT_DEADBAND_RST;
      state_r       <= S_IDLE;
      lockout_r     <= '0;
      last_button_r <= 1'b0;
      hold_r        <= 1'b0;
      target_r      <= '0;
      last_drift_r  <= '0;
      last_corr_r   <= '0;
      div_start_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      gain_r        <= gain_nxt;
      mp_r          <= mp_nxt;
      tdb_r         <= tdb_nxt;
      ddb_r         <= ddb_nxt;
      state_r       <= state_nxt;
      lockout_r     <= lockout_nxt;
      last_button_r <= last_button_nxt;
      hold_r        <= hold_nxt;
      target_r      <= target_nxt;
      last_drift_r  <= last_drift_nxt;
      last_corr_r   <= last_corr_nxt;
      div_start_r   <= div_start_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    heading_r    <= heading_nxt;
    rate_neg_r   <= rate_neg_nxt;
    rprod_r      <= rprod_nxt;
    d_r          <= d_nxt;
    ad_r         <= ad_nxt;
    gprod_r      <= gprod_nxt;
    g_r          <= g_nxt;
    mprod_r      <= mprod_nxt;
    c_r          <= c_nxt;
    oprod_r      <= oprod_nxt;
    m_r          <= m_nxt;
    den_r        <= den_nxt;
    num_r        <= num_nxt;
    pm_r         <= pm_nxt;
    div_a_r      <= div_a_nxt;
    div_b_r      <= div_b_nxt;
    res_neg_r    <= res_neg_nxt;
    res_corr_r   <= res_corr_nxt;
    res_drift_r  <= res_drift_nxt;
    out_corr_r   <= out_corr_nxt;
    out_drift_r  <= out_drift_nxt;
    out_hold_r   <= out_hold_nxt;
    out_target_r <= out_target_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_correction = out_corr_r;
  assign out_hold_on    = out_hold_r;
  assign out_drift_out  = out_drift_r;
  assign out_target_out = out_target_r;

  `HHC_ASSERT_NOW(a_lockout_max, 1'b1, lockout_r <= LOCKOUT_TICKS, "lockout count above limit")
  `HHC_ASSERT_NOW(a_off_zero, out_valid_r && !out_hold_r,
                  out_corr_r == '0 && out_drift_r == '0, "nonzero result with hold off")
  `HHC_ASSERT_NOW(a_done_waiting, div_done, state_r == S_PDIV, "divider finished outside a wait")
  `HHC_ASSERT_NEXT(a_drift_range, state_r == S_DRIFT, d_r <= PI_Q && d_r >= -PI_Q, "wrapped drift out of range")

endmodule

`default_nettype wire

[sim/tb_heading_hold_correction_top.sv]
// Self-checking testbench for heading_hold_correction_top: a directed table, then random
// control ticks over several register settings, each result checked against the table or a predictor.
// Depends on hhc_pkg and the heading_hold_correction_top RTL only.
`timescale 1ns / 100ps

module tb_heading_hold_correction_top;
  import hhc_pkg::*;

  localparam int RUN_LIMIT = 400000;
  localparam int PHASE_TICKS = 88;
  localparam int TAIL_CYCLES = 80;

  typedef struct packed {
    logic        button;
    logic [13:0] turn;
    logic [14:0] heading;
    logic [17:0] rate;
  } tick_t;

  typedef struct packed {
    logic [15:0] correction;
    logic        hold_on;
    logic [14:0] drift;
    logic [14:0] target;
  } result_t;

  typedef struct packed {
    tick_t   stim;
    logic    typed;
    result_t want;
  } dir_row_t;

  // Rows with typed set carry a result that can be read straight off the spec.
  localparam dir_row_t DIR_ROWS [24] = '{
    '{'{1'b0, 14'd0, 15'd1000, 18'd0}, 1'b1, '{16'd0, 1'b0, 15'd0, 15'd0}},
    '{'{1'b0, 14'h1FFF, 15'h7FFF, 18'h1FFFF}, 1'b1, '{16'd0, 1'b0, 15'd0, 15'd0}},
    '{'{1'b0, 14'h2000, 15'd0, 18'h20000}, 1'b1, '{16'd0, 1'b0, 15'd0, 15'd0}},
    '{'{1'b1, 14'd0, 15'd5000, 18'd0}, 1'b1, '{16'd0, 1'b1, 15'd0, 15'd5000}},
    '{'{1'b1, 14'd0, 15'd5100, 18'd0}, 1'b0, '0},
    '{'{1'b1, 14'd0, 15'd5000, 18'd0}, 1'b0, '0},
    '{'{1'b1, 14'd0, 15'd4990, 18'd0}, 1'b0, '0},
    '{'{1'b1, 14'd0, 15'd4900, 18'd0}, 1'b0, '0},
    '{'{1'b1, 14'd0, 15'd4700, 18'd0}, 1'b0, '0},
    '{'{1'b1, 14'd0, 15'd4300, 18'd0}, 1'b0, '0},
    '{'{1'b1, 14'd0, 15'd3500, 18'd0}, 1'b0, '0},
    '{'{1'b1, 14'd0, 15'd5400, 18'd0}, 1'b0, '0},
    '{'{1'b1, 14'd4096, 15'd100, -18'sd20000}, 1'b1, '{16'd0, 1'b1, 15'd0, 15'd25436}},
    '{'{1'b1, -14'sd4096, 15'd25700, 18'd50000}, 1'b1, '{16'd0, 1'b1, 15'd0, 15'd964}},
    '{'{1'b1, 14'd328, 15'd13964, 18'd0}, 1'b0, '0},
    '{'{1'b1, 14'd0, 15'd32767, 18'd0}, 1'b0, '0},
    '{'{1'b0, 14'd0, 15'd8000, 18'd0}, 1'b1, '{16'd0, 1'b1, 15'd0, 15'd8000}},
    '{'{1'b1, 14'd0, 15'd8000, 18'd0}, 1'b0, '0},
    '{'{1'b0, 14'd0, 15'd8100, 18'd0}, 1'b0, '0},
    '{'{1'b1, -14'sd328, 15'd7900, 18'd0}, 1'b0, '0},
    '{'{1'b0, 14'd329, 15'd8000, 18'd123}, 1'b0, '0},
    '{'{1'b1, 14'd0, 15'd8000, 18'd0}, 1'b0, '0},
    '{'{1'b1, 14'd0, 15'd12345, 18'd0}, 1'b1, '{16'd0, 1'b0, 15'd0, 15'd12345}},
    '{'{1'b1, 14'h1FFF, 15'd0, 18'h1FFFF}, 1'b1, '{16'd0, 1'b0, 15'd0, 15'd12345}}
  };

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_hold_button = 1'b0;
  logic signed [13:0] in_turn_demand = '0;
  logic [14:0] in_heading_now = '0;
  logic signed [17:0] in_spin_rate = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_correction;
  logic out_hold_on;
  logic signed [14:0] out_drift_out;
  logic [14:0] out_target_out;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  heading_hold_correction_top uut (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  int cycle_count = 0;
  int err_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  result_t pending_results[$];

  // Predictor copy of the registers and the block state.
  longint gain_q = 4096;
  longint min_pwr = 1229;
  longint turn_db = 328;
  longint drift_db = 18;
  logic [2:0] lock_cnt = '0;
  logic prev_btn = 1'b0;
  logic hold_q = 1'b0;
  logic [14:0] tgt_q = '0;
  longint prev_drift = 0;
  longint prev_corr = 0;

  // Random walk state for well-formed tick sequences.
  int walk_h = 6000;
  int walk_dir = 1;
  logic btn_lvl = 1'b0;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic longint mag_of(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Correction from a wrapped drift, with overshoot damping and growth boost.
  function automatic longint drift_steer(longint d);
    longint c, g, pw, ad, m, lc, s, den, num;
    c = 0;
    ad = mag_of(d);
    if (ad >= drift_db) begin
      g = mag_of(d * gain_q);
      if (g > HALF_Q24) g = HALF_Q24;
      pw = (g * (4096 - min_pwr)) / (longint'(1) << 24) + min_pwr;
      c = (d < 0) ? -pw : pw;
    end
    if ((d > 0 && prev_drift < 0) || (d < 0 && prev_drift >= 0)) begin
      c = (c * 3) / OVS_DIV;
    end else if (10 * ad > 9 * mag_of(prev_drift)) begin
      m = mag_of(c);
      lc = mag_of(prev_corr);
      s = (d < 0) ? -1 : 1;
      den = 4096 + 100 * ad;
      if (lc > m) m = lc;
      if (c < 0) m = -m;
      num = 101 * den + 10000 * s * (d - prev_drift);
      c = (m * num) / (100 * den);
    end
    if (c > 32767) c = 32767;
    if (c < -32768) c = -32768;
    prev_corr = c;
    prev_drift = d;
    return c;
  endfunction

  function automatic result_t hold_tick_result(tick_t t);
    result_t r;
    longint turn, heading, rate, trg, drift, corr;
    turn = longint'($signed(t.turn));
    heading = longint'(t.heading);
    rate = longint'($signed(t.rate));
    corr = 0;
    drift = 0;
    if (lock_cnt != 0) begin
      lock_cnt = lock_cnt - 3'd1;
    end else begin
      if (t.button && !prev_btn) hold_q = !hold_q;
      if (t.button != prev_btn) begin
        lock_cnt = LOCKOUT_TICKS;
        tgt_q = t.heading;
      end
      prev_btn = t.button;
    end
    if (hold_q) begin
      if (mag_of(turn) > turn_db) begin
        trg = heading + rate / RATE_DIV;
        if (trg < 0) trg += TWO_PI_Q;
        if (trg > TWO_PI_Q) trg -= TWO_PI_Q;
        tgt_q = trg[14:0];
      end else begin
        drift = longint'(tgt_q) - heading;
        if (drift > PI_Q) drift -= TWO_PI_Q;
        else if (drift < -PI_Q) drift += TWO_PI_Q;
        corr = drift_steer(drift);
      end
    end
    r.correction = corr[15:0];
    r.hold_on = hold_q;
    r.drift = drift[14:0];
    r.target = tgt_q;
    return r;
  endfunction

  // Mostly a drifting heading with hold engaged; one tick in ten is pure noise.
  function automatic tick_t random_tick();
    tick_t t;
    int span, lim;
    if ($urandom_range(9) == 0) begin
      t.button = 1'($urandom);
      t.turn = 14'($urandom);
      t.heading = 15'($urandom);
      t.rate = 18'($urandom);
      return t;
    end
    if (lock_cnt != 0) begin
      if ($urandom_range(9) < 3) btn_lvl = !btn_lvl;
    end else if (!hold_q) begin
      if ($urandom_range(1) == 1) btn_lvl = !btn_lvl;
    end else if ($urandom_range(24) == 0) begin
      btn_lvl = !btn_lvl;
    end
    t.button = btn_lvl;
    if ($urandom_range(9) < 3) begin
      t.turn = 14'($urandom);
    end else begin
      lim = int'(turn_db);
      t.turn = 14'(int'($urandom_range(2 * lim)) - lim);
    end
    if ($urandom_range(4) == 0) walk_dir = -walk_dir;
    case ($urandom_range(3))
      0: span = 15;
      1: span = 150;
      2: span = 1500;
      default: span = 6000;
    endcase
    walk_h += walk_dir * int'($urandom_range(span));
    if (walk_h < 0) walk_h += TWO_PI_Q;
    if (walk_h > TWO_PI_Q) walk_h -= TWO_PI_Q;
    if ($urandom_range(19) == 0) t.heading = 15'($urandom_range(32767, 25000));
    else t.heading = 15'(walk_h);
    if ($urandom_range(4) == 0) t.rate = 18'($urandom);
    else t.rate = 18'(int'($urandom_range(10000)) - 5000);
    return t;
  endfunction

  task automatic send_tick(tick_t t, logic typed, result_t want);
    while (int'($urandom_range(99)) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_hold_button <= t.button;
    in_turn_demand <= t.turn;
    in_heading_now <= t.heading;
    in_spin_rate <= t.rate;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (typed) begin
      void'(hold_tick_result(t));
      pending_results.push_back(want);
    end else begin
      pending_results.push_back(hold_tick_result(t));
    end
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_DRIFT_GAIN: gain_q = longint'($signed(val));
      REG_MIN_POWER: min_pwr = longint'(val[12:0]);
      REG_TURN_DEADBAND: turn_db = longint'(val[12:0]);
      default: drift_db = longint'(val[12:0]);
    endcase
  endtask

  task automatic wait_results_done();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_result();
    result_t want;
    if (pending_results.size() == 0) begin
      $error("result beat with nothing expected: correction %0d target %0d",
             out_correction, out_target_out);
      err_count++;
    end else begin
      want = pending_results.pop_front();
      if (out_correction !== want.correction) begin
        $error("correction: expected %0d, got %0d", $signed(want.correction), out_correction);
        err_count++;
      end
      if (out_hold_on !== want.hold_on) begin
        $error("hold_on: expected %0d, got %0d", want.hold_on, out_hold_on);
        err_count++;
      end
      if (out_drift_out !== want.drift) begin
        $error("drift_out: expected %0d, got %0d", $signed(want.drift), out_drift_out);
        err_count++;
      end
      if (out_target_out !== want.target) begin
        $error("target_out: expected %0d, got %0d", want.target, out_target_out);
        err_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_stall === 1'b0) check_result();
    out_stall <= (int'($urandom_range(99)) < stall_pct);
  end

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("tb_heading_hold_correction_top: done, errors");
    $finish;
  end

  initial begin
    logic [15:0] gain_v;
    logic [12:0] minp_v, turn_v, drift_v;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 24; i++) send_tick(DIR_ROWS[i].stim, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    in_valid <= 1'b0;
    wait_results_done();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          gain_v = 16'd4096; minp_v = 13'd1229; turn_v = 13'd328; drift_v = 13'd18;
          idle_pct = 0; stall_pct = 0;
        end
        1: begin
          gain_v = 16'h7FFF; minp_v = 13'd4096; turn_v = 13'd0; drift_v = 13'd0;
          idle_pct = 77; stall_pct = 0;
        end
        2: begin
          gain_v = 16'h8000; minp_v = 13'd0; turn_v = 13'd4096; drift_v = 13'd4096;
          idle_pct = 0; stall_pct = 77;
        end
        3: begin
          gain_v = 16'd0; minp_v = 13'h1FFF; turn_v = 13'h1FFF; drift_v = 13'h1FFF;
          idle_pct = 28; stall_pct = 28;
        end
        default: begin
          gain_v = 16'($urandom);
          minp_v = ($urandom_range(3) == 0) ? 13'($urandom) : 13'($urandom_range(4096));
          turn_v = 13'($urandom_range(4096));
          drift_v = 13'($urandom_range(600));
          idle_pct = (ph == 4) ? 0 : 28;
          stall_pct = idle_pct;
        end
      endcase
      write_reg(REG_DRIFT_GAIN, gain_v);
      write_reg(REG_MIN_POWER, {3'd0, minp_v});
      write_reg(REG_TURN_DEADBAND, {3'd0, turn_v});
      write_reg(REG_DRIFT_DEADBAND, {3'd0, drift_v});
      repeat (PHASE_TICKS) send_tick(random_tick(), 1'b0, '0);
      in_valid <= 1'b0;
      wait_results_done();
    end

    // Any stray beat after the last expected one shows up as an error here.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_heading_hold_correction_top: done, clean");
    end else begin
      $display("tb_heading_hold_correction_top: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/hhc_pkg.sv
design/hhc_div.sv
design/heading_hold_correction_top.sv
sim/tb_heading_hold_correction_top.sv
